[src/kpf_pkg.sv]
// Shared types and constants of the keypad press queue.
package kpf_pkg;

  // Keypad geometry and field widths.
  localparam int unsigned ROW_COUNT = 4;
  localparam int unsigned COL_COUNT = 5;
  localparam int unsigned KEY_COUNT = ROW_COUNT * COL_COUNT;
  localparam int unsigned SAMPLE_W  = KEY_COUNT;
  localparam int unsigned CODE_W    = 5;
  localparam int unsigned COUNT_W   = 5;
  localparam int unsigned ROW_W     = 2;
  localparam int unsigned COL_W     = 3;
  localparam int unsigned KEY_W     = 5;

  // Kind of work a request asks for.
  typedef enum logic {
    OP_SCAN = 1'b0,
    OP_READ = 1'b1
  } kpf_op_e;

  // Request word as it arrives on the input channel.
  typedef struct packed {
    logic                req_type;
    logic [SAMPLE_W-1:0] scan_columns;
  } kpf_in_t;

  // Result word as it leaves on the output channel.
  typedef struct packed {
    logic [CODE_W-1:0]  key_code;
    logic               new_press;
    logic [COUNT_W-1:0] buffer_count;
  } kpf_out_t;

  // Classified command passed from the front end to the back end.
  typedef struct packed {
    kpf_op_e             op;
    logic [SAMPLE_W-1:0] sample;
  } kpf_cmd_t;

endpackage

[src/kpf_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module kpf_ram #(
  parameter int unsigned WIDTH = 5,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/kpf_front.sv]
// Front end: takes request words, classifies them and queues them for the back end.
module kpf_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  kpf_pkg::kpf_in_t in_word_i,
  output logic             cmd_valid_o,
  input  logic             cmd_take_i,
  output kpf_pkg::kpf_cmd_t cmd_o
);
  import kpf_pkg::*;

  // Two-entry queue of words waiting for the back end.
  localparam int unsigned QUEUE_DEPTH = 2;

  kpf_cmd_t   queue_q [QUEUE_DEPTH];
  kpf_cmd_t   cmd_new;
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       in_take;

  // Classify the incoming word.
  always_comb begin
    cmd_new.op     = in_word_i.req_type ? OP_READ : OP_SCAN;
    cmd_new.sample = in_word_i.scan_columns;
  end

  assign in_stall_o  = (fill_q == 2'(QUEUE_DEPTH));
  assign in_take     = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = queue_q[rd_ptr_q];

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (in_take) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (cmd_take_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (in_take && !cmd_take_i) begin
      fill_d = fill_q + 2'd1;
    end else if (!in_take && cmd_take_i) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

[src/kpf_back.sv]
// Back end: walks the keys of a scan, keeps the press FIFO and forms result words.
module kpf_back #(
  parameter int unsigned FIFO_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_take_o,
  input  kpf_pkg::kpf_cmd_t cmd_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output kpf_pkg::kpf_out_t out_word_o
);
  import kpf_pkg::*;

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_READ   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [SAMPLE_W-1:0] sample_q, sample_d;
  logic [KEY_COUNT-1:0] prev_q, prev_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [COL_W-1:0]    col_q, col_d;
  logic [PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CODE_W-1:0]   code_q, code_d;
  logic                press_q, press_d;
  logic                out_valid_q, out_valid_d;
  kpf_out_t            out_word_q, out_word_d;

  logic [KEY_W-1:0]    key_idx;
  logic [KEY_W-1:0]    bit_idx;
  logic                level;
  logic                push;
  logic                full;
  logic [SUM_W-1:0]    slot_sum;
  logic [PTR_W-1:0]    wr_addr;
  logic [PTR_W-1:0]    rd_ptr_inc;
  logic                ram_re;
  logic [CODE_W-1:0]   ram_rdata;
  logic                out_free;

  // Key index is col*4+row; its sample bit is row*5+col.
  assign key_idx = {col_q, row_q};
  assign bit_idx = KEY_W'(row_q) * KEY_W'(COL_COUNT) + KEY_W'(col_q);
  assign level   = sample_q[bit_idx];
  assign push    = (state_q == ST_SCAN) && !level && prev_q[key_idx];
  assign full    = (count_q == CNT_W'(FIFO_DEPTH));

  // Slot after the newest entry; when full, the oldest slot is overwritten.
  always_comb begin
    slot_sum = SUM_W'(rd_ptr_q) + SUM_W'(count_q);
    if (slot_sum >= SUM_W'(FIFO_DEPTH)) begin
      slot_sum = slot_sum - SUM_W'(FIFO_DEPTH);
    end
    wr_addr = full ? rd_ptr_q : PTR_W'(slot_sum);
  end

  assign rd_ptr_inc = (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign cmd_take_o = (state_q == ST_IDLE) && cmd_valid_i;
  assign ram_re     = cmd_take_o && (cmd_i.op == OP_READ) && (count_q != '0);

  // Sequencer for scans and reads.
  always_comb begin
    state_d     = state_q;
    sample_d    = sample_q;
    prev_d      = prev_q;
    row_d       = row_q;
    col_d       = col_q;
    rd_ptr_d    = rd_ptr_q;
    count_d     = count_q;
    code_d      = code_q;
    press_d     = press_q;
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          code_d  = '0;
          press_d = 1'b0;
          if (cmd_i.op == OP_SCAN) begin
            sample_d = cmd_i.sample;
            row_d    = '0;
            col_d    = '0;
            state_d  = ST_SCAN;
          end else if (count_q != '0) begin
            rd_ptr_d = rd_ptr_inc;
            count_d  = count_q - CNT_W'(1);
            state_d  = ST_READ;
          end else begin
            state_d  = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        prev_d[key_idx] = level;
        if (push) begin
          press_d = 1'b1;
          if (full) begin
            rd_ptr_d = rd_ptr_inc;
          end else begin
            count_d = count_q + CNT_W'(1);
          end
        end
        if (col_q == COL_W'(COL_COUNT - 1)) begin
          col_d = '0;
          if (row_q == ROW_W'(ROW_COUNT - 1)) begin
            state_d = ST_FINISH;
          end else begin
            row_d = row_q + ROW_W'(1);
          end
        end else begin
          col_d = col_q + COL_W'(1);
        end
      end
      ST_READ: begin
        code_d  = ram_rdata;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_word_d.key_code     = code_q;
          out_word_d.new_press    = press_q;
          out_word_d.buffer_count = COUNT_W'(count_q);
          out_valid_d             = 1'b1;
          state_d                 = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prev_q      <= '0;
      rd_ptr_q    <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prev_q      <= prev_d;
      rd_ptr_q    <= rd_ptr_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working payload registers.
  always_ff @(posedge clk_i) begin
    sample_q   <= sample_d;
    row_q      <= row_d;
    col_q      <= col_d;
    code_q     <= code_d;
    press_q    <= press_d;
    out_word_q <= out_word_d;
  end

  // Press FIFO storage.
  kpf_ram #(
    .WIDTH(CODE_W),
    .DEPTH(FIFO_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (push),
    .waddr_i(wr_addr),
    .wdata_i(CODE_W'(key_idx) + CODE_W'(1)),
    .re_i   (ram_re),
    .raddr_i(rd_ptr_q),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

[src/matrix_keypad_press_fifo_top.sv]
// Top level of the keypad press scanner and its key FIFO.
// A scan word carries the active-low samples of a 4-row by 5-column keypad; every key that
// reads low now and read high on the previous scan is a new press, and its code (key index
// plus one, index col*4+row) goes into a FIFO of FIFO_DEPTH entries that drops its oldest
// entry when full. A read word pops the oldest code, or returns 0 when the FIFO is empty.
// Every word gives exactly one result word. Words wait in a two-entry input queue, so the
// input side keeps accepting while a result waits to be taken. In the back end a scan steps
// through entry, a step for each of the twenty keys and the result step; a read steps
// through entry, the registered read of the FIFO RAM and the result step when a code is
// held, and skips the read step when the FIFO is empty. The result step waits for as long
// as an earlier result word is still stalled. The first scan after reset never reports a
// press, since every key starts out as held.
module matrix_keypad_press_fifo_top #(
  parameter int unsigned FIFO_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  kpf_pkg::kpf_in_t  in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output kpf_pkg::kpf_out_t out_word_o
);
  import kpf_pkg::*;

  kpf_cmd_t cmd;
  logic     cmd_valid;
  logic     cmd_take;

  // Front end: input queue and classification.
  kpf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .cmd_valid_o(cmd_valid),
    .cmd_take_i (cmd_take),
    .cmd_o      (cmd)
  );

  // Back end: key walk, FIFO and result register.
  kpf_back #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_take_o (cmd_take),
    .cmd_i      (cmd),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

endmodule

[verif/tb_matrix_keypad_press_fifo_top.sv]
// Self-checking testbench for the keypad press scanner and its key FIFO.
module tb_matrix_keypad_press_fifo_top;
  timeunit 1ns;
  timeprecision 1ps;

  import kpf_pkg::*;

  localparam int unsigned FIFO_DEPTH   = 16;
  localparam int unsigned STUCK_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam logic [SAMPLE_W-1:0] ALL_RELEASED = '1;
  localparam logic [SAMPLE_W-1:0] ALL_PRESSED  = '0;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  kpf_in_t  in_word_i;
  logic     out_valid_o;
  logic     out_stall_i;
  kpf_out_t out_word_o;

  // Predicted keypad and FIFO state, updated as each word is accepted.
  logic [KEY_COUNT-1:0] last_level;
  logic [CODE_W-1:0]    code_store [FIFO_DEPTH];
  int unsigned          oldest_slot;
  int unsigned          held_keys;

  kpf_out_t    pending_results [$];
  int unsigned mismatch_count;
  int unsigned stuck_cycles;
  bit          send_gaps_on;
  bit          stall_on;

  matrix_keypad_press_fifo_top #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  // Free-running clock.
  always #5 clk_i = ~clk_i;

  // Works out the result of one word and advances the predicted state.
  function automatic kpf_out_t predict_keypad_result(kpf_in_t w);
    kpf_out_t    r;
    int unsigned key;
    int unsigned slot;
    logic        lvl;
    r = '0;
    if (w.req_type == OP_SCAN) begin
      // Walk rows outer, columns inner, so presses enter the FIFO in that order.
      for (int unsigned row = 0; row < ROW_COUNT; row++) begin
        for (int unsigned col = 0; col < COL_COUNT; col++) begin
          key = col * ROW_COUNT + row;
          lvl = w.scan_columns[row * COL_COUNT + col];
          if (!lvl && last_level[key]) begin
            // A full FIFO loses its oldest code to make room.
            if (held_keys >= FIFO_DEPTH) begin
              oldest_slot = (oldest_slot + 1) % FIFO_DEPTH;
              held_keys   = FIFO_DEPTH - 1;
            end
            slot             = (oldest_slot + held_keys) % FIFO_DEPTH;
            code_store[slot] = CODE_W'(key + 1);
            held_keys++;
            r.new_press = 1'b1;
          end
          last_level[key] = lvl;
        end
      end
    end else if (held_keys > 0) begin
      r.key_code  = code_store[oldest_slot];
      oldest_slot = (oldest_slot + 1) % FIFO_DEPTH;
      held_keys--;
    end
    r.buffer_count = COUNT_W'(held_keys);
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap(bit enabled);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!enabled || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic kpf_in_t kp_word(kpf_op_e op, logic [SAMPLE_W-1:0] cols);
    kpf_in_t w;
    w.req_type     = op;
    w.scan_columns = cols;
    return w;
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_columns();
    return SAMPLE_W'($urandom_range(0, 20'hFFFFF));
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // Presents one word, after an optional gap, and holds it until it is taken.
  task automatic send_word(kpf_in_t w);
    int unsigned gap;
    gap = pick_gap(send_gaps_on);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Result side back-pressure.
  initial begin
    int unsigned hold;
    out_stall_i = 1'b0;
    forever begin
      hold = pick_gap(stall_on);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  end

  // Predicts on every accepted input word and checks every accepted result word.
  always @(posedge clk_i) begin
    kpf_out_t want;
    bit       moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        pending_results.push_back(predict_keypad_result(in_word_i));
        moved = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result word %h with nothing expected", out_word_o));
        end else begin
          want = pending_results.pop_front();
          if (out_word_o.key_code !== want.key_code)
            report_mismatch($sformatf("key_code got %0d expected %0d",
                                      out_word_o.key_code, want.key_code));
          if (out_word_o.new_press !== want.new_press)
            report_mismatch($sformatf("new_press got %0b expected %0b",
                                      out_word_o.new_press, want.new_press));
          if (out_word_o.buffer_count !== want.buffer_count)
            report_mismatch($sformatf("buffer_count got %0d expected %0d",
                                      out_word_o.buffer_count, want.buffer_count));
        end
      end
      stuck_cycles <= moved ? 0 : stuck_cycles + 1;
    end
  end

  // Ends the run if nothing moves on either side for too long.
  initial begin
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // Read from an empty FIFO, then a first scan with every key low.
  task automatic test_reset_state();
    send_word(kp_word(OP_READ, random_columns()));
    send_word(kp_word(OP_SCAN, ALL_PRESSED));
  endtask

  // Twenty presses at once overflow the FIFO; reads ignore their columns.
  task automatic test_overflow();
    send_word(kp_word(OP_SCAN, ALL_RELEASED));
    send_word(kp_word(OP_SCAN, ALL_PRESSED));
    repeat (3) send_word(kp_word(OP_READ, random_columns()));
  endtask

  // Lowest and highest key codes, then drain past empty.
  task automatic test_extreme_codes();
    send_word(kp_word(OP_SCAN, ALL_RELEASED));
    send_word(kp_word(OP_SCAN, 20'h7FFFE));
    repeat (16) send_word(kp_word(OP_READ, random_columns()));
  endtask

  // Keys go down and up a few at a time, with reads mixed in at a varying rate.
  task automatic run_press_traffic(int unsigned count);
    logic [SAMPLE_W-1:0] levels;
    int unsigned         read_pct;
    int unsigned         flips;
    levels   = ALL_RELEASED;
    read_pct = 40;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 100 == 0) read_pct = $urandom_range(10, 70);
      if ($urandom_range(0, 99) < read_pct) begin
        send_word(kp_word(OP_READ, random_columns()));
      end else begin
        flips = $urandom_range(0, 3);
        repeat (flips) levels[$urandom_range(0, SAMPLE_W - 1)] ^= 1'b1;
        // Now and then every key is released or pressed together.
        if ($urandom_range(0, 99) < 3) levels = ALL_RELEASED;
        else if ($urandom_range(0, 99) < 2) levels = ALL_PRESSED;
        send_word(kp_word(OP_SCAN, levels));
      end
    end
  endtask

  task automatic test_press_sequences();
    send_gaps_on = 1'b1;
    stall_on     = 1'b1;
    run_press_traffic(1200);
  endtask

  task automatic test_back_to_back();
    send_gaps_on = 1'b0;
    stall_on     = 1'b0;
    run_press_traffic(200);
  endtask

  // Unrelated scan samples and reads, no key history.
  task automatic test_noise();
    send_gaps_on = 1'b1;
    stall_on     = 1'b1;
    repeat (300) begin
      send_word(kp_word($urandom_range(0, 99) < 40 ? OP_READ : OP_SCAN, random_columns()));
    end
  endtask

  // Reset, test sequence and final verdict.
  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_word_i      = '0;
    last_level     = '0;
    oldest_slot    = 0;
    held_keys      = 0;
    mismatch_count = 0;
    stuck_cycles   = 0;
    send_gaps_on   = 1'b1;
    stall_on       = 1'b1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_overflow();
    test_extreme_codes();
    test_press_sequences();
    test_back_to_back();
    test_noise();

    in_valid_i <= 1'b0;
    stall_on = 1'b1;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
